// ===== src/tae_pkg.sv =====
// Package for the tempo autocorrelation estimator: widths, reset values,
// register indexes, state type and the structs passed between modules.
// No dependencies.
package tae_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 16;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int LAG_W   = 10;
    localparam int WIDE_W  = ((CNT_W > LAG_W) ? CNT_W : LAG_W) + 1;
    localparam int PROD_W  = 2 * VALUE_WIDTH;
    localparam int SUM_W   = 48;
    localparam int SCALE_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LAG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_SCALE = 2'd2;

    localparam logic [LAG_W-1:0]   MIN_LAG_RESET     = 10'd25;
    localparam logic [LAG_W-1:0]   MAX_LAG_RESET     = 10'd86;
    localparam logic [SCALE_W-1:0] TEMPO_SCALE_RESET = 32'd1323000;
    localparam logic [SCALE_W-1:0] DEFAULT_TEMPO_Q8  = 32'd30720;
    localparam logic [CNT_W-1:0]   MIN_VALUES        = CNT_W'(4);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int OUT_DATA_W = 96;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SEARCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
        logic [LAG_W-1:0] lo;
        logic [LAG_W-1:0] hi;
    } corr_cmd_t;

    typedef struct packed {
        logic             done;
        logic [LAG_W-1:0] lag;
        logic [SUM_W-1:0] sum;
    } corr_res_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             final_lag;
        logic [LAG_W-1:0] lag;
    } pair_tag_t;

endpackage

// ===== src/tae_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module tae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/tae_corr.sv =====
// Lag search engine: walks the onset store for each lag, multiplies and
// accumulates pairs, keeps the first lag with the largest sum.
// Depends on tae_pkg; drives the read ports of tae_ram.
module tae_corr (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tae_pkg::corr_cmd_t                    cmd,
    output logic [tae_pkg::ADDR_W-1:0]            raddr_a,
    output logic [tae_pkg::ADDR_W-1:0]            raddr_b,
    input  logic [tae_pkg::VALUE_WIDTH-1:0]       rdata_a,
    input  logic [tae_pkg::VALUE_WIDTH-1:0]       rdata_b,
    output tae_pkg::corr_res_t                    res
);

    logic                         issue_reg;
    logic [tae_pkg::LAG_W-1:0]    lag_reg;
    logic [tae_pkg::ADDR_W-1:0]   idx_reg;
    logic [tae_pkg::CNT_W-1:0]    n_reg;
    logic [tae_pkg::LAG_W-1:0]    hi_reg;

    tae_pkg::pair_tag_t           tag_next;
    tae_pkg::pair_tag_t           p1_reg;
    tae_pkg::pair_tag_t           p2_reg;
    tae_pkg::pair_tag_t           p3_reg;
    logic [tae_pkg::PROD_W-1:0]   prod_reg;
    logic [tae_pkg::SUM_W-1:0]    acc_reg;
    logic [tae_pkg::SUM_W-1:0]    acc_next;
    logic [tae_pkg::SUM_W:0]      acc_wide;

    logic [tae_pkg::SUM_W-1:0]    best_sum_reg;
    logic [tae_pkg::LAG_W-1:0]    best_lag_reg;
    logic                         found_reg;
    logic                         done_reg;

    logic [tae_pkg::WIDE_W-1:0]   pos_b;
    logic [tae_pkg::WIDE_W-1:0]   last_pos;

    assign pos_b    = tae_pkg::WIDE_W'(idx_reg) + tae_pkg::WIDE_W'(lag_reg);
    assign last_pos = tae_pkg::WIDE_W'(n_reg) - tae_pkg::WIDE_W'(1);
    assign raddr_a  = idx_reg;
    assign raddr_b  = pos_b[tae_pkg::ADDR_W-1:0];

    always_comb
    begin
        tag_next.valid     = issue_reg;
        tag_next.first     = (idx_reg == '0);
        tag_next.last      = (pos_b == last_pos);
        tag_next.final_lag = (lag_reg == hi_reg);
        tag_next.lag       = lag_reg;
    end

    // saturating accumulate; the first pair of a lag restarts the sum
    assign acc_wide = {1'b0, acc_reg} + (tae_pkg::SUM_W + 1)'(prod_reg);
    always_comb
    begin
        if (p2_reg.first)
        begin
            acc_next = tae_pkg::SUM_W'(prod_reg);
        end
        else if (acc_wide[tae_pkg::SUM_W])
        begin
            acc_next = tae_pkg::SUM_MAX;
        end
        else
        begin
            acc_next = acc_wide[tae_pkg::SUM_W-1:0];
        end
    end

    // address sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            lag_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            hi_reg    <= '0;
        end
        else if (cmd.start)
        begin
            issue_reg <= 1'b1;
            lag_reg   <= cmd.lo;
            idx_reg   <= '0;
            n_reg     <= cmd.n;
            hi_reg    <= cmd.hi;
        end
        else if (issue_reg)
        begin
            if (tag_next.last)
            begin
                idx_reg <= '0;
                if (tag_next.final_lag)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    lag_reg <= lag_reg + 1'b1;
                end
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // pipeline tags: RAM read, multiply, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else
        begin
            p1_reg <= tag_next;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= tae_pkg::PROD_W'(rdata_a) * tae_pkg::PROD_W'(rdata_b);
        if (p2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // best-lag compare, one lag per completed sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= '0;
            best_lag_reg <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= p3_reg.valid && p3_reg.last && p3_reg.final_lag;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (p3_reg.valid && p3_reg.last)
            begin
                found_reg <= 1'b1;
                if (!found_reg || (acc_reg > best_sum_reg))
                begin
                    best_sum_reg <= acc_reg;
                    best_lag_reg <= p3_reg.lag;
                end
            end
        end
    end

    always_comb
    begin
        res.done = done_reg;
        res.lag  = best_lag_reg;
        res.sum  = best_sum_reg;
    end

endmodule

// ===== src/tae_div.sv =====
// Restoring divider, one quotient bit per cycle: tempo_scale / lag.
// Depends on tae_pkg.
module tae_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tae_pkg::SCALE_W-1:0]   dividend,
    input  logic [tae_pkg::LAG_W-1:0]     divisor,
    output logic                          done,
    output logic [tae_pkg::SCALE_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(tae_pkg::SCALE_W + 1);

    logic                          busy_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [tae_pkg::SCALE_W-1:0]   quot_reg;
    logic [tae_pkg::LAG_W-1:0]     rem_reg;
    logic [tae_pkg::LAG_W-1:0]     div_reg;
    logic                          done_reg;

    logic [tae_pkg::LAG_W:0]       trial;
    logic                          take;
    logic [tae_pkg::LAG_W:0]       diff;

    assign trial = {rem_reg, quot_reg[tae_pkg::SCALE_W-1]};
    assign take  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(tae_pkg::SCALE_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[tae_pkg::SCALE_W-2:0], take};
            rem_reg  <= take ? diff[tae_pkg::LAG_W-1:0] : trial[tae_pkg::LAG_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== src/tempo_autocorrelation_estimator_unit.sv =====
// Top level of the tempo autocorrelation estimator.
// Depends on tae_pkg, tae_ram, tae_corr and tae_div.
// Usage:
//   s_* stream carries onset values (tdata) with tlast on the final value of a
//   sequence. Values load into the onset store at one transfer per cycle
//   while s_tready is high; values past the store depth are dropped, a
//   dropped tlast still ends it. After the tlast transfer s_tready drops
//   while the lag search runs; one result transfer leaves on m_* per
//   sequence. From tlast to result: a setup state, then the lag search
//   (one product pair per cycle, set by the two read ports of the store),
//   the read/multiply/accumulate/compare drain, the bit-serial tempo
//   divider and the output register. Too short: no search or divide;
//   empty lag range: no search, but the divider still runs.
//   The result sits in an output register: when the receiver stalls, the
//   next sequence still loads, and only the emit of the following result
//   waits for m_tready.
//   The user writes registers through cfg_we/cfg_index/cfg_data only while
//   idle; the block does not enforce it. Reset (rst_n low, asynchronous)
//   clears control state, count and the registers to their defaults; the
//   store itself has no reset and is only read below the current count.
module tempo_autocorrelation_estimator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [15:0] onset_value
    input  logic [15:0]                        s_tdata,
    input  logic                               s_tlast,   // last_value
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: [9:0] best_lag, [57:10] best_correlation, [89:58] tempo_q8,
    //          [95:90] zero
    output logic [tae_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: [0] too_short
    output logic [0:0]                         m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [tae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tae_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tae_pkg::state_t state_reg;
    tae_pkg::state_t state_next;

    logic [tae_pkg::LAG_W-1:0]    min_lag_reg;
    logic [tae_pkg::LAG_W-1:0]    max_lag_reg;
    logic [tae_pkg::SCALE_W-1:0]  scale_reg;

    logic [tae_pkg::CNT_W-1:0]    count_reg;
    logic [tae_pkg::CNT_W-1:0]    n_reg;
    logic [tae_pkg::CNT_W-1:0]    n_next;
    logic                         store_full;

    logic [tae_pkg::LAG_W-1:0]    res_lag_reg;
    logic [tae_pkg::SUM_W-1:0]    res_sum_reg;
    logic [tae_pkg::SCALE_W-1:0]  res_tempo_reg;
    logic                         res_short_reg;

    logic [tae_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tvalid_reg;

    // handshake / control decode
    logic                         in_xfer;
    logic                         ram_we;
    logic                         out_free;
    logic                         is_short;
    logic                         range_empty;
    logic [tae_pkg::LAG_W-1:0]    lo;
    logic [tae_pkg::LAG_W-1:0]    hi;
    logic [tae_pkg::WIDE_W-1:0]   n_minus_1;

    tae_pkg::corr_cmd_t           corr_cmd;
    tae_pkg::corr_res_t           corr_res;
    logic                         div_start;
    logic [tae_pkg::LAG_W-1:0]    div_divisor;
    logic                         div_done;
    logic [tae_pkg::SCALE_W-1:0]  div_quot;

    logic [tae_pkg::ADDR_W-1:0]      raddr_a;
    logic [tae_pkg::ADDR_W-1:0]      raddr_b;
    logic [tae_pkg::VALUE_WIDTH-1:0] rdata_a;
    logic [tae_pkg::VALUE_WIDTH-1:0] rdata_b;

    assign store_full = (count_reg == tae_pkg::CNT_W'(tae_pkg::STORE_DEPTH));
    assign n_next     = store_full ? count_reg : count_reg + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;

    // lag range: min clamped to at least 1, max to n - 1
    assign n_minus_1   = tae_pkg::WIDE_W'(n_reg) - tae_pkg::WIDE_W'(1);
    assign lo          = (min_lag_reg == '0) ? tae_pkg::LAG_W'(1) : min_lag_reg;
    assign hi          = (tae_pkg::WIDE_W'(max_lag_reg) > n_minus_1)
                         ? n_minus_1[tae_pkg::LAG_W-1:0] : max_lag_reg;
    assign is_short    = (n_reg < tae_pkg::MIN_VALUES);
    assign range_empty = (lo > hi);

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tae_pkg::ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = tae_pkg::ST_SETUP;
                end
            end
            tae_pkg::ST_SETUP:
            begin
                if (is_short)
                begin
                    state_next = tae_pkg::ST_EMIT;
                end
                else if (range_empty)
                begin
                    state_next = tae_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = tae_pkg::ST_SEARCH;
                end
            end
            tae_pkg::ST_SEARCH:
            begin
                if (corr_res.done)
                begin
                    state_next = tae_pkg::ST_DIVIDE;
                end
            end
            tae_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = tae_pkg::ST_EMIT;
                end
            end
            tae_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tae_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = tae_pkg::ST_LOAD;
            end
        endcase
    end

    // output decode
    always_comb
    begin
        s_tready       = 1'b0;
        corr_cmd.start = 1'b0;
        corr_cmd.n     = n_reg;
        corr_cmd.lo    = lo;
        corr_cmd.hi    = hi;
        div_start      = 1'b0;
        div_divisor    = corr_res.lag;
        case (state_reg)
            tae_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
            end
            tae_pkg::ST_SETUP:
            begin
                corr_cmd.start = !is_short && !range_empty;
                div_start      = !is_short && range_empty;
                div_divisor    = lo;
            end
            tae_pkg::ST_SEARCH:
            begin
                div_start = corr_res.done;
            end
            default:
            begin
            end
        endcase
    end

    assign in_xfer = s_tvalid && s_tready;
    assign ram_we  = in_xfer && !store_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tae_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lag_reg <= tae_pkg::MIN_LAG_RESET;
            max_lag_reg <= tae_pkg::MAX_LAG_RESET;
            scale_reg   <= tae_pkg::TEMPO_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tae_pkg::REG_MIN_LAG:     min_lag_reg <= cfg_data[tae_pkg::LAG_W-1:0];
                tae_pkg::REG_MAX_LAG:     max_lag_reg <= cfg_data[tae_pkg::LAG_W-1:0];
                tae_pkg::REG_TEMPO_SCALE: scale_reg   <= cfg_data[tae_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // value count; the count restarts after every tlast
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            n_reg     <= '0;
        end
        else if (in_xfer)
        begin
            if (s_tlast)
            begin
                count_reg <= '0;
                n_reg     <= n_next;
            end
            else
            begin
                count_reg <= n_next;
            end
        end
    end

    // result holding registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tae_pkg::ST_SETUP:
            begin
                res_short_reg <= is_short;
                res_sum_reg   <= '0;
                res_lag_reg   <= is_short ? '0 : lo;
                res_tempo_reg <= tae_pkg::DEFAULT_TEMPO_Q8;
            end
            tae_pkg::ST_SEARCH:
            begin
                if (corr_res.done)
                begin
                    res_lag_reg <= corr_res.lag;
                    res_sum_reg <= corr_res.sum;
                end
            end
            tae_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_tempo_reg <= div_quot;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == tae_pkg::ST_EMIT) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == tae_pkg::ST_EMIT) && out_free)
        begin
            m_tdata_reg <= tae_pkg::OUT_DATA_W'({res_tempo_reg, res_sum_reg, res_lag_reg});
            m_tuser_reg <= res_short_reg;
        end
    end

    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tvalid   = m_tvalid_reg;

    tae_ram #(
        .WIDTH (tae_pkg::VALUE_WIDTH),
        .DEPTH (tae_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (count_reg[tae_pkg::ADDR_W-1:0]),
        .wdata   (s_tdata[tae_pkg::VALUE_WIDTH-1:0]),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    tae_corr u_corr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (corr_cmd),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .res     (corr_res)
    );

    tae_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

// ===== src/tae_checker.sv =====
// Port-level checker for the tempo autocorrelation estimator, bound to the
// top level. Depends on tae_pkg.
module tae_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tlast,
    input  logic [tae_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // input closes right after the tlast transfer while the search runs
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input open after tlast transfer");

    // short sequence carries the default fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[9:0] == 10'd0) && (m_tdata[57:10] == 48'd0)
        && (m_tdata[89:58] == tae_pkg::DEFAULT_TEMPO_Q8))
    else $error("short result fields wrong");

    // a searched result never reports lag zero, padding stays clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || (m_tdata[9:0] != 10'd0)) && (m_tdata[95:90] == 6'd0))
    else $error("bad lag or padding in result");

endmodule

bind tempo_autocorrelation_estimator_unit tae_checker u_tae_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
